// ===== rtl/xds_pkg.sv =====
// Shared types and constants for the XOR-distance node sorter.
// No dependencies; every other file but xds_ram imports this package.
package xds_pkg;

  localparam int ID_W      = 64;
  localparam int TAG_W     = 8;
  localparam int DIST_W    = 2 * ID_W;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LOW  = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]  id_high;
    logic [ID_W-1:0]  id_low;
    logic [TAG_W-1:0] tag;
  } xds_entry_t;

  localparam int ENTRY_W = $bits(xds_entry_t);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_CATCH
  } xds_state_t;

endpackage

// ===== rtl/xds_if.sv =====
// Valid/ready channel interfaces for node input and sorted output.
// Depends on xds_pkg for field widths.
interface xds_in_if import xds_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  node_id_high;
  logic [ID_W-1:0]  node_id_low;
  logic [TAG_W-1:0] node_tag;
  logic             set_last;

  modport source (output valid, node_id_high, node_id_low, node_tag, set_last, input ready);
  modport sink   (input valid, node_id_high, node_id_low, node_tag, set_last, output ready);
endinterface

interface xds_out_if import xds_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  out_id_high;
  logic [ID_W-1:0]  out_id_low;
  logic [TAG_W-1:0] out_tag;
  logic             overflowed;
  logic             out_last;

  modport source (output valid, out_id_high, out_id_low, out_tag, overflowed, out_last,
                  input ready);
  modport sink   (input valid, out_id_high, out_id_low, out_tag, overflowed, out_last,
                  output ready);
endinterface

// ===== rtl/xds_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module xds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/xds_cmp.sv =====
// Shared distance unit: XOR distance of one stored node to the target and
// strict less-than against the best distance so far. Depends on xds_pkg.
module xds_cmp import xds_pkg::*; (
  input  xds_entry_t        entry,
  input  logic [ID_W-1:0]   target_high,
  input  logic [ID_W-1:0]   target_low,
  input  logic [DIST_W-1:0] best_dist,
  output logic [DIST_W-1:0] distance,
  output logic              closer
);

  assign distance = {entry.id_high ^ target_high, entry.id_low ^ target_low};
  assign closer   = distance < best_dist;

endmodule

// ===== rtl/xor_distance_node_sorter.sv =====
// XOR-distance node sorter: top level with sequencer, node store and output register.
// Load: one node per cycle while ready. After set_last, each result is found by a scan of
// the stored nodes, one store read each through the shared distance unit, then drain, fetch
// (which waits for the output register to be free) and capture; input is blocked until the run is sorted.
// Reset clears control state and the target registers; the node store is not cleared.
// Depends on xds_pkg, xds_if, xds_ram and xds_cmp.
module xor_distance_node_sorter import xds_pkg::*; #(
  parameter int MAX_NODES = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  xds_in_if.sink               node_in,
  xds_out_if.source            node_out
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  xds_state_t state, state_next;

  logic [ID_W-1:0]      target_high;
  logic [ID_W-1:0]      target_low;
  logic [CW-1:0]        node_count;
  logic                 overflow_flag;
  logic [CW-1:0]        run_n;
  logic                 run_ovf;
  logic [IW-1:0]        scan_idx;
  logic                 pend_valid;
  logic [IW-1:0]        pend_idx;
  logic                 best_valid;
  logic [IW-1:0]        best_idx;
  logic [DIST_W-1:0]    best_dist;
  logic [MAX_NODES-1:0] done_mask;
  logic [CW-1:0]        emit_cnt;
  logic                 out_valid;
  xds_entry_t           out_entry;
  logic                 out_ovf;
  logic                 out_last_r;

  logic                 in_fire;
  logic                 out_fire;
  logic                 store_ok;
  logic                 ram_we;
  logic [IW-1:0]        ram_raddr;
  xds_entry_t           wr_entry;
  logic [ENTRY_W-1:0]   rd_data;
  xds_entry_t           rd_entry;
  logic [DIST_W-1:0]    cand_dist;
  logic                 cand_closer;
  logic                 scan_end;
  logic                 run_end;
  logic                 take_cand;

  assign in_fire   = node_in.valid && node_in.ready;
  assign out_fire  = node_out.valid && node_out.ready;
  assign store_ok  = node_count < CW'(MAX_NODES);
  assign scan_end  = CW'(scan_idx) == run_n - CW'(1);
  assign run_end   = emit_cnt + CW'(1) == run_n;
  assign rd_entry  = xds_entry_t'(rd_data);
  assign take_cand = pend_valid && !done_mask[pend_idx] && (!best_valid || cand_closer);

  assign wr_entry.id_high = node_in.node_id_high;
  assign wr_entry.id_low  = node_in.node_id_low;
  assign wr_entry.tag     = node_in.node_tag;

  xds_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_NODES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(node_count[IW-1:0]),
    .wdata(wr_entry),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  xds_cmp u_cmp (
    .entry      (rd_entry),
    .target_high(target_high),
    .target_low (target_low),
    .best_dist  (best_dist),
    .distance   (cand_dist),
    .closer     (cand_closer)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      target_high <= '0;
      target_low  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TARGET_HIGH: target_high <= cfg_wdata;
        CFG_TARGET_LOW:  target_low  <= cfg_wdata;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_fire && node_in.set_last) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_FETCH;
      ST_FETCH: begin
        if (!out_valid) state_next = ST_CATCH;
      end
      ST_CATCH: state_next = run_end ? ST_LOAD : ST_SCAN;
      default:  state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    node_in.ready = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = scan_idx;
    unique case (state)
      ST_LOAD: begin
        node_in.ready = 1'b1;
        ram_we        = in_fire && store_ok;
      end
      ST_FETCH: ram_raddr = best_idx;
      ST_SCAN, ST_DRAIN, ST_CATCH: ram_raddr = scan_idx;
      default: ram_raddr = scan_idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      node_count    <= '0;
      overflow_flag <= 1'b0;
      run_n         <= '0;
      run_ovf       <= 1'b0;
      scan_idx      <= '0;
      pend_valid    <= 1'b0;
      pend_idx      <= '0;
      best_valid    <= 1'b0;
      best_idx      <= '0;
      done_mask     <= '0;
      emit_cnt      <= '0;
      out_valid     <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= (state == ST_SCAN);
      pend_idx   <= scan_idx;

      if (take_cand) begin
        best_valid <= 1'b1;
        best_idx   <= pend_idx;
      end

      if (out_fire) out_valid <= 1'b0;

      unique case (state)
        ST_LOAD: begin
          if (in_fire && node_in.set_last) begin
            run_n         <= store_ok ? node_count + CW'(1) : node_count;
            run_ovf       <= overflow_flag || !store_ok;
            node_count    <= '0;
            overflow_flag <= 1'b0;
            emit_cnt      <= '0;
            done_mask     <= '0;
            scan_idx      <= '0;
            best_valid    <= 1'b0;
          end else if (in_fire && store_ok) begin
            node_count <= node_count + CW'(1);
          end else if (in_fire) begin
            overflow_flag <= 1'b1;
          end
        end
        ST_SCAN: scan_idx <= scan_idx + IW'(1);
        ST_DRAIN: ;
        ST_FETCH: begin
          if (!out_valid) done_mask[best_idx] <= 1'b1;
        end
        ST_CATCH: begin
          out_valid  <= 1'b1;
          emit_cnt   <= emit_cnt + CW'(1);
          scan_idx   <= '0;
          best_valid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take_cand) best_dist <= cand_dist;
    if (state == ST_CATCH) begin
      out_entry  <= rd_entry;
      out_ovf    <= run_ovf;
      out_last_r <= run_end;
    end
  end

  assign node_out.valid       = out_valid;
  assign node_out.out_id_high = out_entry.id_high;
  assign node_out.out_id_low  = out_entry.id_low;
  assign node_out.out_tag     = out_entry.tag;
  assign node_out.overflowed  = out_ovf;
  assign node_out.out_last    = out_last_r;

  a_fetch_has_pick: assert property (@(posedge clk) disable iff (rst)
    state == ST_FETCH |-> best_valid && !done_mask[best_idx])
    else $error("fetch without an unsent closest node");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    state != ST_LOAD |-> emit_cnt < run_n)
    else $error("emit count beyond run length");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    state == ST_CATCH && run_end |=> state == ST_LOAD && out_valid && node_out.out_last)
    else $error("final result did not return to load");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    node_count <= CW'(MAX_NODES))
    else $error("node count beyond capacity");

endmodule
